FILE: rtl/salc_pkg.sv
// Shared types and constants for the set-associative lookup cache.
// No dependencies; imported by the cache top level and its checker.
`default_nettype none

package salc_pkg;

    localparam int KEY_W      = 64;
    localparam int VALUE_W    = 64;
    localparam int OP_W       = 2;
    localparam int SET_LSB    = 4;
    localparam int DEF_SETS   = 16;
    localparam int DEF_WAYS   = 4;

    localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL       = 2'd1;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] fill_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] found_value;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/set_assoc_lookup_cache.sv
// Set-associative key-to-value lookup cache with per-set round-robin fill.
// Depends on salc_pkg (request/response structs, operation codes, defaults).
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_t  (operation, key, fill_value)
//   rsp       out        rsp_valid / rsp_ready   rsp_t  (hit, found_value)
//
// One request per cycle unless a stalled rsp backs up a lookup; a lookup is registered
// through the set index stage, then the way compare stage feeding the response register.
// Fills and invalidates leave no response and retire from the first stage.
// Reset clears the round-robin pointers and row fill marks and sets the stale flag;
// the key and value memories are never cleared, entries past a row's fill
// count read as empty. A stalled rsp holds the pipeline back one stage at a time.
`default_nettype none

module set_assoc_lookup_cache
    import salc_pkg::*;
#(
    parameter int SETS = DEF_SETS,
    parameter int WAYS = DEF_WAYS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FOLD_BITS = KEY_W - SET_LSB;
    localparam int SUM_W     = $clog2(64 * SETS);

    // weight of key bit (SET_LSB + bit_pos) in the set index, i.e. 2^bit_pos mod SETS
    function automatic int set_weight(input int bit_pos);
        int w;
        begin
            w = 1 % SETS;
            for (int i = 0; i < bit_pos; i++)
            begin
                w = (w * 2) % SETS;
            end
            return w;
        end
    endfunction

    // ---------------- set index: fold key bits, then reduce ----------------
    logic [SUM_W-1:0] fold_term [FOLD_BITS];
    logic [SUM_W-1:0] fold_sum;
    logic [SUM_W-1:0] fold_rem;
    logic [SET_W-1:0] req_set;

    for (genvar gi = 0; gi < FOLD_BITS; gi++)
    begin : g_fold
        localparam int WT = set_weight(gi);
        assign fold_term[gi] = req.key[SET_LSB + gi] ? SUM_W'(WT) : '0;
    end

    always_comb
    begin
        fold_sum = '0;
        for (int i = 0; i < FOLD_BITS; i++)
        begin
            fold_sum = fold_sum + fold_term[i];
        end
        // sum stays below 64*SETS, so six conditional subtracts finish it
        fold_rem = fold_sum;
        for (int j = 5; j >= 0; j--)
        begin
            if (fold_rem >= SUM_W'(SETS << j))
            begin
                fold_rem = fold_rem - SUM_W'(SETS << j);
            end
        end
        req_set = SET_W'(fold_rem);
    end

    // ---------------- pipeline control ----------------
    logic             s0_valid_reg;
    req_t             s0_req_reg;
    logic [SET_W-1:0] s0_set_reg;

    logic             s1_valid_reg;
    logic             s1_flush_reg;
    logic [KEY_W-1:0] s1_key_reg;
    logic [WAYS-1:0]  s1_live_reg;
    logic [KEY_W-1:0]   rd_key_reg [WAYS];
    logic [VALUE_W-1:0] rd_val_reg [WAYS];

    logic out_valid_reg;
    rsp_t rsp_reg;

    logic out_adv;
    logic s1_adv;
    logic s0_is_lookup;
    logic s0_go;
    logic lookup_go;
    logic fill_go;
    logic inval_go;
    logic in_go;

    assign out_adv      = !out_valid_reg || rsp_ready;
    assign s1_adv       = !s1_valid_reg || out_adv;
    assign s0_is_lookup = (s0_req_reg.operation == OP_LOOKUP);
    assign s0_go        = s0_valid_reg && (!s0_is_lookup || s1_adv);
    assign lookup_go    = s0_go && s0_is_lookup;
    assign fill_go      = s0_go && (s0_req_reg.operation == OP_FILL);
    assign inval_go     = s0_go && (s0_req_reg.operation == OP_INVALIDATE);
    assign req_ready    = !s0_valid_reg || s0_go;
    assign in_go        = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s0_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go)
        begin
            s0_req_reg <= req;
            s0_set_reg <= req_set;
        end
    end

    // ---------------- replacement state ----------------
    logic [WAY_W-1:0] next_way_reg [SETS];
    logic             full_reg     [SETS];
    logic             stale_reg;
    logic [WAY_W-1:0] fill_way;
    logic [WAYS-1:0]  row_live;

    assign fill_way = next_way_reg[s0_set_reg];

    // a way holds data once the pointer has passed it since the last flush
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            row_live[w] = full_reg[s0_set_reg] || (WAY_W'(w) < fill_way);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= 1'b1;
            for (int s = 0; s < SETS; s++)
            begin
                next_way_reg[s] <= '0;
                full_reg[s]     <= 1'b0;
            end
        end
        else if (lookup_go && stale_reg)
        begin
            stale_reg <= 1'b0;
            for (int s = 0; s < SETS; s++)
            begin
                next_way_reg[s] <= '0;
                full_reg[s]     <= 1'b0;
            end
        end
        else if (fill_go)
        begin
            if (fill_way == WAY_W'(WAYS - 1))
            begin
                next_way_reg[s0_set_reg] <= '0;
                full_reg[s0_set_reg]     <= 1'b1;
            end
            else
            begin
                next_way_reg[s0_set_reg] <= fill_way + WAY_W'(1);
            end
        end
        else if (inval_go)
        begin
            stale_reg <= 1'b1;
        end
    end

    // ---------------- key / value memories ----------------
    logic [KEY_W-1:0]   key_mem [WAYS][SETS];
    logic [VALUE_W-1:0] val_mem [WAYS][SETS];

    always_ff @(posedge clk)
    begin
        if (fill_go)
        begin
            key_mem[fill_way][s0_set_reg] <= s0_req_reg.key;
            val_mem[fill_way][s0_set_reg] <= s0_req_reg.fill_value;
        end
        if (lookup_go)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                rd_key_reg[w] <= key_mem[w][s0_set_reg];
                rd_val_reg[w] <= val_mem[w][s0_set_reg];
            end
        end
    end

    // ---------------- stage 1: capture lookup context ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (lookup_go)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_go)
        begin
            s1_flush_reg <= stale_reg;
            s1_key_reg   <= s0_req_reg.key;
            s1_live_reg  <= row_live;
        end
    end

    // ---------------- way compare ----------------
    logic [WAYS-1:0] way_hit;
    rsp_t            cmp_rsp;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            way_hit[w] = s1_live_reg[w] && (rd_key_reg[w] == s1_key_reg)
                         && (rd_val_reg[w] != '0);
        end
        cmp_rsp = '0;
        // walk down so the lowest matching way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (way_hit[w] && !s1_flush_reg)
            begin
                cmp_rsp.hit         = 1'b1;
                cmp_rsp.found_value = rd_val_reg[w];
            end
        end
    end

    // ---------------- response register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            rsp_reg <= cmp_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/salc_checker.sv
// Port-level checks for the lookup cache, bound onto set_assoc_lookup_cache.
// Depends on salc_pkg for the request/response structs.
`default_nettype none

module salc_checker
    import salc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // a miss never carries a value
    miss_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.hit) |-> (rsp.found_value == '0))
        else $error("miss response carries a nonzero value");

    // empty entries never hit, so a hit always returns a nonzero value
    hit_value_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.hit) |-> (rsp.found_value != '0))
        else $error("hit response carries a zero value");

    // hold a stalled response
    rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response dropped or changed");

    // hold a waiting request
    req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_ready) |=> (req_valid && $stable(req)))
        else $error("waiting request dropped or changed");

    // a response cannot appear in the first cycle out of reset
    no_early_rsp: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("response valid straight out of reset");

endmodule

bind set_assoc_lookup_cache salc_checker u_salc_checker (.*);

`default_nettype wire

FILE: tb/sv/set_assoc_lookup_cache_test.sv
// Self-checking testbench for set_assoc_lookup_cache: directed and random
// lookup/fill/invalidate requests, predicted by a behavioral cache model.
// Depends on salc_pkg and the set_assoc_lookup_cache RTL.
`timescale 1ns / 1ps

module set_assoc_lookup_cache_test;
    import salc_pkg::*;

    localparam int SETS          = DEF_SETS;
    localparam int WAYS          = DEF_WAYS;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int TAIL_CYCLES   = 8;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Behavioral copy of the cache contents
    logic [KEY_W-1:0]   model_keys   [SETS*WAYS];
    logic [VALUE_W-1:0] model_values [SETS*WAYS];
    int unsigned        rr_ptr       [SETS];
    bit                 flush_pending;

    rsp_t   lookup_results_q [$];
    req_t   pending_req_q [$];
    bit     drain_first_q [$];
    int     requests_queued = 0;
    int     requests_sent = 0;
    int     error_count = 0;

    int     burst_left;
    int     gap_left;
    int     stall_mode;
    int     stall_left;
    rsp_t   want;

    set_assoc_lookup_cache #(
        .SETS(SETS),
        .WAYS(WAYS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic cache_model_step(input req_t r);
        int unsigned set_idx;
        int unsigned way;
        rsp_t res;
        bit matched;
        set_idx = int'((r.key >> SET_LSB) % SETS);
        res = '0;
        matched = 1'b0;
        case (r.operation)
            OP_LOOKUP:
            begin
                if (flush_pending)
                begin
                    // first lookup after an invalidate wipes everything and misses
                    for (int i = 0; i < SETS*WAYS; i++)
                    begin
                        model_keys[i] = '0;
                        model_values[i] = '0;
                    end
                    for (int s = 0; s < SETS; s++)
                        rr_ptr[s] = 0;
                    flush_pending = 1'b0;
                end
                else
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (!matched && model_keys[set_idx*WAYS + w] == r.key &&
                            model_values[set_idx*WAYS + w] != '0)
                        begin
                            matched = 1'b1;
                            res.hit = 1'b1;
                            res.found_value = model_values[set_idx*WAYS + w];
                        end
                    end
                end
                lookup_results_q.push_back(res);
            end
            OP_FILL:
            begin
                way = rr_ptr[set_idx] % WAYS;
                model_keys[set_idx*WAYS + way] = r.key;
                model_values[set_idx*WAYS + way] = r.fill_value;
                rr_ptr[set_idx] = (way + 1) % WAYS;
            end
            OP_INVALIDATE:
                flush_pending = 1'b1;
            default:
                ;
        endcase
    endtask

    function automatic void queue_request(input logic [OP_W-1:0] op,
                                          input logic [KEY_W-1:0] key,
                                          input logic [VALUE_W-1:0] value,
                                          input bit drain_first);
        req_t r;
        r.operation = op;
        r.key = key;
        r.fill_value = value;
        pending_req_q.push_back(r);
        drain_first_q.push_back(drain_first);
        requests_queued++;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        // crowd most keys into a few sets so the round-robin wraps often
        if ($urandom_range(0, 4) < 3)
            k[SET_LSB +: 4] = 4'($urandom_range(0, 2));
        return k;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 15)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    // Driver: bursts of requests separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (req_valid && !req_ready)
        begin
            // hold the request until accepted
        end
        else
        begin
            if (req_valid)
                requests_sent++;
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_req_q.size() == 0 ||
                     (drain_first_q[0] && (req_valid || lookup_results_q.size() != 0)))
            begin
                req_valid <= 1'b0;
            end
            else
            begin
                req <= pending_req_q.pop_front();
                void'(drain_first_q.pop_front());
                req_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Response sink: stall pattern switches randomly among four modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(5, 60);
            end
            else
                stall_left--;
            case (stall_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= 1'($urandom_range(0, 1));
                2: rsp_ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ready <= (stall_left % 16) >= 10;
            endcase
        end
    end

    // Monitor: check responses, then predict the request accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (lookup_results_q.size() == 0)
                begin
                    $error("response with no lookup outstanding: hit %0d found_value %h",
                           rsp.hit, rsp.found_value);
                    error_count++;
                end
                else
                begin
                    want = lookup_results_q.pop_front();
                    if (rsp.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, rsp.hit);
                        error_count++;
                    end
                    if (rsp.found_value !== want.found_value)
                    begin
                        $error("found_value: expected %h, actual %h",
                               want.found_value, rsp.found_value);
                        error_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                cache_model_step(req);
        end
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0] key_pool [$];
        logic [KEY_W-1:0] k;
        int counted;
        int unsigned r;
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [KEY_W-1:0] key_d;
        logic [KEY_W-1:0] key_e;
        logic [KEY_W-1:0] key_f;

        for (int i = 0; i < SETS*WAYS; i++)
        begin
            model_keys[i] = '0;
            model_values[i] = '0;
        end
        for (int s = 0; s < SETS; s++)
            rr_ptr[s] = 0;
        flush_pending = 1'b1;

        // Directed: set 5 unless noted; key 8 is in set 0, the alternating-bit key in set 10
        key_a = 64'h0000_0000_0000_0050;
        key_b = 64'h0000_0000_0000_0150;
        key_d = 64'h0000_0000_0000_0250;
        key_e = 64'h0000_0000_0000_0350;
        key_f = 64'h1234_5678_9abc_de50;
        queue_request(OP_FILL, key_a, 64'h1111, 1'b0);      // fill while stale
        queue_request(OP_LOOKUP, key_a, '0, 1'b0);          // flushes, misses
        queue_request(OP_LOOKUP, key_a, '0, 1'b0);
        queue_request(OP_FILL, key_a, '1, 1'b0);
        queue_request(OP_LOOKUP, key_a, '0, 1'b0);
        queue_request(OP_FILL, key_a, '0, 1'b0);            // duplicate key, zero value
        queue_request(OP_LOOKUP, key_a, '0, 1'b0);
        queue_request(OP_FILL, key_b, 64'd2, 1'b0);
        queue_request(OP_FILL, '1, 64'd3, 1'b0);            // set 15
        queue_request(OP_LOOKUP, '1, '0, 1'b0);
        queue_request(OP_FILL, key_d, 64'd4, 1'b0);
        queue_request(OP_FILL, key_e, 64'd5, 1'b0);         // wraps, evicts way 0
        queue_request(OP_LOOKUP, key_a, '0, 1'b0);
        queue_request(OP_LOOKUP, key_e, '0, 1'b0);
        queue_request(OP_LOOKUP, key_b, '0, 1'b0);
        queue_request(OP_FILL, '0, 64'd6, 1'b0);            // key zero, set 0
        queue_request(OP_LOOKUP, '0, '0, 1'b0);
        queue_request(OP_LOOKUP, 64'h8, '0, 1'b0);
        queue_request(OP_UNUSED, key_e, 64'd9, 1'b0);       // ignored
        queue_request(OP_LOOKUP, key_e, '0, 1'b0);
        queue_request(OP_INVALIDATE, key_e, '0, 1'b0);
        queue_request(OP_FILL, key_f, 64'd7, 1'b0);
        queue_request(OP_LOOKUP, key_f, '0, 1'b0);
        queue_request(OP_LOOKUP, key_e, '0, 1'b0);
        queue_request(OP_FILL, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
        queue_request(OP_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, '0, 1'b0);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (key_pool.size() == 0 || $urandom_range(0, 9) < 3)
            begin
                key_pool.push_back(fresh_key());
                if (key_pool.size() > 20)
                    void'(key_pool.pop_front());
            end
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            r = $urandom_range(0, 99);
            if (r < 40)
                queue_request(OP_FILL, ($urandom_range(0, 9) < 8) ? k : fresh_key(),
                              pick_value(), counted == 600 || counted == 1300);
            else if (r < 85)
                queue_request(OP_LOOKUP, ($urandom_range(0, 9) < 8) ? k : fresh_key(),
                              {$urandom, $urandom}, 1'b0);
            else if (r < 88)
                queue_request(OP_INVALIDATE, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
            else if (r < 90)
            begin
                queue_request(OP_UNUSED, k, {$urandom, $urandom}, 1'b0);
                continue;
            end
            else
                queue_request(OP_LOOKUP, k ^ (64'd1 << $urandom_range(0, 63)), '0, 1'b0);
            counted++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_sent < requests_queued || lookup_results_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && lookup_results_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
